@@ hdl/kst_pkg.sv @@
package kst_pkg;

  // table geometry
  localparam int SLOTS  = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // field widths
  localparam int KEY_W = 23;
  localparam int TS_W  = 32;
  localparam int ID_W  = 16;

  // x / 12 for x < 128 as (x * 43) >> 9
  localparam int DIV12_MUL   = 43;
  localparam int DIV12_SHIFT = 9;
  localparam int DIV12_PW    = 13;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  // table update kinds
  typedef enum logic [1:0] {
    UPD_TOUCH,
    UPD_INSERT,
    UPD_DELETE
  } upd_kind_t;

  // search record passed from cell to cell
  typedef struct packed {
    logic             active;
    logic [KEY_W-1:0] key;
    logic             hit_found;
    slot_idx_t        hit_idx;
    logic [ID_W-1:0]  hit_id;
    logic             free_found;
    slot_idx_t        free_idx;
    logic             vic_found;
    slot_idx_t        vic_idx;
    logic [TS_W-1:0]  vic_ts;
    slot_idx_t        vic_rank;
    logic [CNT_W-1:0] nvalid;
  } scan_t;

  // update broadcast to every cell
  typedef struct packed {
    logic             en;
    upd_kind_t        kind;
    slot_idx_t        target;
    logic [KEY_W-1:0] key;
    logic [TS_W-1:0]  ts;
    logic [ID_W-1:0]  id;
    logic             set_rank;
    slot_idx_t        rank;
  } upd_t;

  // cell contents seen by the controller
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    slot_idx_t       rank;
  } stat_t;

  // key: month code, merged site bits, serial number
  function automatic logic [KEY_W-1:0] make_key(input logic [7:0] b0, input logic [7:0] b1,
                                                 input logic [7:0] b2);
    logic [1:0] site;
    site = {b1[1], b1[0] | b0[7]};
    return {b0[6:0], site, b2, b1[7:2]};
  endfunction

  function automatic logic [3:0] div12(input logic [6:0] x);
    logic [DIV12_PW-1:0] p;
    p = DIV12_PW'(x) * DIV12_PW'(DIV12_MUL);
    return 4'(p >> DIV12_SHIFT);
  endfunction

endpackage

@@ hdl/kst_cell.sv @@
module kst_cell (
  input  logic             clk,
  input  logic             rst,
  input  kst_pkg::slot_idx_t idx,
  input  kst_pkg::scan_t   carry_in,
  output kst_pkg::scan_t   carry_out,
  input  kst_pkg::upd_t    upd,
  output kst_pkg::stat_t   stat
);
  import kst_pkg::*;

  logic             valid;
  slot_idx_t        rank;
  logic [KEY_W-1:0] key;
  logic [TS_W-1:0]  last_ts;
  logic [ID_W-1:0]  id;
  scan_t            scan_next;
  logic             is_target;

  assign is_target = (upd.target == idx);
  assign stat      = '{valid: valid, id: id, rank: rank};

  // fold this slot into the running search
  always_comb begin
    scan_next = carry_in;
    if (valid) begin
      scan_next.nvalid = carry_in.nvalid + CNT_W'(1);
      if (!carry_in.hit_found && key == carry_in.key) begin
        scan_next.hit_found = 1'b1;
        scan_next.hit_idx   = idx;
        scan_next.hit_id    = id;
      end
      if (!carry_in.vic_found || last_ts < carry_in.vic_ts ||
          (last_ts == carry_in.vic_ts && rank < carry_in.vic_rank)) begin
        scan_next.vic_found = 1'b1;
        scan_next.vic_idx   = idx;
        scan_next.vic_ts    = last_ts;
        scan_next.vic_rank  = rank;
      end
    end else if (!carry_in.free_found) begin
      scan_next.free_found = 1'b1;
      scan_next.free_idx   = idx;
    end
  end

  // hand the record to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.active <= 1'b0;
    end else if (carry_in.active) begin
      carry_out <= scan_next;
    end else begin
      carry_out.active <= 1'b0;
    end
  end

  // valid bit and insertion order
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      unique case (upd.kind)
        UPD_INSERT: begin
          if (is_target) begin
            valid <= 1'b1;
            if (upd.set_rank) begin
              rank <= upd.rank;
            end
          end
        end
        UPD_DELETE: begin
          if (is_target) begin
            valid <= 1'b0;
          end else if (valid && rank > upd.rank) begin
            rank <= rank - SLOT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (upd.en && is_target) begin
      if (upd.kind == UPD_INSERT) begin
        key <= upd.key;
        id  <= upd.id;
      end
      if (upd.kind == UPD_INSERT || upd.kind == UPD_TOUCH) begin
        last_ts <= upd.ts;
      end
    end
  end

endmodule

@@ hdl/keyed_slot_table_lru_core.sv @@
// channel  dir  tdata (low bit up)                                    tuser
// s_*      in   serial_byte0[7:0] serial_byte1[15:8] serial_byte2     mode
//               [23:16] timestamp[55:24] delete_slot[57:56]
// m_*      out  slot_index[1:0] entry_id[17:2] was_hit[18]            -
//               was_evicted[19] fresh_entry[20] year_digit[24:21]
//               month_number[28:25] site_code[31:29] serial_number[45:32]
//               done_ok[46]
// a lookup walks the row of SLOTS cells one cell a cycle; a delete reads its slot directly
// reset: synchronous, clears all valid bits, insertion ranks and the id counter
// a finished result waits in the output register while m_tready is low; one
// more transaction is taken meanwhile and holds at its last step until then
module keyed_slot_table_lru_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // serial_byte0, serial_byte1, serial_byte2, timestamp,
                                 // delete_slot, zero pad
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // slot_index, entry_id, was_hit, was_evicted, fresh_entry,
                                 // year_digit, month_number, site_code, serial_number,
                                 // done_ok, zero pad
);
  import kst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DEL  = 2'd3;

  logic [1:0]      state;
  logic [ID_W-1:0] next_id;

  // captured request
  logic [7:0]      req_b0;
  logic [7:0]      req_b1;
  logic [7:0]      req_b2;
  logic [TS_W-1:0] req_ts;
  logic [1:0]      req_del;

  scan_t           chain [SLOTS+1];
  stat_t           stat  [SLOTS];
  scan_t           pend;
  upd_t            upd;

  logic            accept;
  logic            out_free;
  logic            fin_fire;
  logic            del_fire;
  slot_idx_t       del_idx;
  stat_t           stat_sel;
  logic            del_ok;
  slot_idx_t       fin_target;
  logic [6:0]      mcode;
  logic [3:0]      year;
  logic [6:0]      mrem;

  // result register
  logic [1:0]      r_slot;
  logic [ID_W-1:0] r_id;
  logic            r_hit;
  logic            r_evicted;
  logic            r_fresh;
  logic [3:0]      r_year;
  logic [3:0]      r_month;
  logic [2:0]      r_site;
  logic [13:0]     r_serial;
  logic            r_done;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign fin_fire = (state == ST_FIN) && out_free;
  assign del_fire = (state == ST_DEL) && out_free;

  // launch a lookup into the first cell
  always_comb begin
    chain[0]        = '0;
    chain[0].active = accept && !s_tuser;
    chain[0].key    = make_key(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
  end

  // row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    kst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (SLOT_W'(i)),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .upd       (upd),
      .stat      (stat[i])
    );
  end

  // delete side
  assign del_idx  = SLOT_W'(req_del);
  assign stat_sel = stat[del_idx];
  assign del_ok   = (int'(req_del) < SLOTS) && stat_sel.valid;

  // lookup decision and field decode
  assign fin_target = pend.hit_found  ? pend.hit_idx :
                      pend.free_found ? pend.free_idx : pend.vic_idx;
  assign mcode      = req_b0[6:0];
  assign year       = div12(mcode);
  assign mrem       = mcode - 7'(year) * 7'd12;

  // table update command
  always_comb begin
    upd = '0;
    if (fin_fire) begin
      upd.en       = 1'b1;
      upd.kind     = pend.hit_found ? UPD_TOUCH : UPD_INSERT;
      upd.target   = fin_target;
      upd.key      = pend.key;
      upd.ts       = req_ts;
      upd.id       = next_id;
      upd.set_rank = pend.free_found;
      upd.rank     = SLOT_W'(pend.nvalid);
    end else if (del_fire && del_ok) begin
      upd.en     = 1'b1;
      upd.kind   = UPD_DELETE;
      upd.target = del_idx;
      upd.rank   = stat_sel.rank;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= s_tuser ? ST_DEL : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain[SLOTS].active) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            state <= ST_IDLE;
          end
        end
        ST_DEL: begin
          if (del_fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request and search capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_b0  <= s_tdata[7:0];
      req_b1  <= s_tdata[15:8];
      req_b2  <= s_tdata[23:16];
      req_ts  <= s_tdata[55:24];
      req_del <= s_tdata[57:56];
    end
    if (chain[SLOTS].active) begin
      pend <= chain[SLOTS];
    end
  end

  // id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= '0;
    end else if (upd.en && upd.kind == UPD_INSERT) begin
      next_id <= next_id + ID_W'(1);
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_fire || del_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      r_slot    <= 2'(fin_target);
      r_id      <= pend.hit_found ? pend.hit_id : next_id;
      r_hit     <= pend.hit_found;
      r_evicted <= !pend.hit_found && !pend.free_found;
      r_fresh   <= !pend.hit_found;
      r_year    <= year;
      r_month   <= 4'(mrem) + 4'd1;
      r_site    <= {1'b0, req_b1[1], req_b1[0] | req_b0[7]} + 3'd1;
      r_serial  <= {req_b2, req_b1[7:2]};
      r_done    <= 1'b1;
    end else if (del_fire) begin
      r_slot    <= req_del;
      r_id      <= del_ok ? stat_sel.id : '0;
      r_hit     <= 1'b0;
      r_evicted <= 1'b0;
      r_fresh   <= 1'b0;
      r_year    <= '0;
      r_month   <= '0;
      r_site    <= '0;
      r_serial  <= '0;
      r_done    <= del_ok;
    end
  end

  assign m_tdata = {1'b0, r_done, r_serial, r_site, r_month, r_year,
                    r_fresh, r_evicted, r_hit, r_id, r_slot};

  // checks
  a_scan_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[SLOTS].active |-> state == ST_SCAN)
    else $error("search record left the row outside a lookup");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted transaction did not start work");

  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (upd.en && upd.kind == UPD_INSERT) |=> next_id == $past(next_id) + ID_W'(1))
    else $error("id counter did not advance on insert");

  a_delete_valid: assert property (@(posedge clk) disable iff (rst)
    (upd.en && upd.kind == UPD_DELETE) |-> stat[upd.target].valid)
    else $error("delete issued for an empty slot");

endmodule
